>>> rtl/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared types and constants for the multi-level priority fifo.
// ----------------------------------------------------------------------------
package mlpf_pkg;

  localparam int NUM_LEVELS_DEF  = 10;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int JOB_BITS_DEF    = 16;

  localparam int JOB_PORT_W   = 16;
  localparam int LEVEL_PORT_W = 4;

  localparam int MID_DEPTH = 4;
  localparam int OQ_DEPTH  = 4;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [LEVEL_PORT_W-1:0]   level;
    status_t                   status;
    logic                      all_empty;
  } cmd_info_t;

  typedef struct packed {
    logic [JOB_PORT_W-1:0]     job;
    logic [LEVEL_PORT_W-1:0]   level;
    status_t                   status;
    logic                      all_empty;
  } result_t;

endpackage

>>> rtl/mlpf_ram.sv
// ----------------------------------------------------------------------------
// mlpf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mlpf_fifo.sv
// ----------------------------------------------------------------------------
// mlpf_fifo
// Small register-based queue with fill count.
// ----------------------------------------------------------------------------
module mlpf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  assign wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? bump(rd_ptr_r) : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = cnt_r;

endmodule

>>> rtl/mlpf_front.sv
// ----------------------------------------------------------------------------
// mlpf_front
// Per-level pointers and counts; classifies each item into a store command.
// ----------------------------------------------------------------------------
module mlpf_front #(
  parameter int NUM_LEVELS  = mlpf_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpf_pkg::LEVEL_DEPTH_DEF,
  parameter int JOB_BITS    = mlpf_pkg::JOB_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   acc,
  input  logic                                   op,
  input  logic [mlpf_pkg::JOB_PORT_W-1:0]        job_in,
  input  logic [mlpf_pkg::LEVEL_PORT_W-1:0]      prio_level,
  output mlpf_pkg::cmd_info_t                    cmd_info,
  output logic [$clog2(NUM_LEVELS)+$clog2(LEVEL_DEPTH)-1:0] cmd_addr,
  output logic [JOB_BITS-1:0]                    cmd_job
);

  localparam int LVL_W = $clog2(NUM_LEVELS);
  localparam int PTR_W = $clog2(LEVEL_DEPTH);
  localparam int CNT_W = $clog2(LEVEL_DEPTH+1);

  logic [PTR_W-1:0] head_r [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r [NUM_LEVELS];
  logic [PTR_W-1:0] tail_nxt [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_nxt [NUM_LEVELS];

  logic [NUM_LEVELS-1:0] ne_w, full_w, last_w, ne_after;
  logic [LVL_W-1:0]      top_lvl, add_lvl;
  logic                  is_add, add_ok, rem_ok, any_ne;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(LEVEL_DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ne_w[i]   = (cnt_r[i] != '0);
      full_w[i] = (cnt_r[i] == CNT_W'(LEVEL_DEPTH));
      last_w[i] = (cnt_r[i] == CNT_W'(1));
    end
  end

  // highest non-empty level
  always_comb begin
    top_lvl = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ne_w[i]) begin
        top_lvl = LVL_W'(i);
      end
    end
  end

  // out-of-range levels saturate to the top level
  assign add_lvl = (int'(prio_level) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS-1)
                                                    : LVL_W'(prio_level);

  assign is_add = (op == mlpf_pkg::OP_ADD);
  assign any_ne = |ne_w;
  assign add_ok = acc & is_add & ~full_w[add_lvl];
  assign rem_ok = acc & ~is_add & any_ne;

  always_comb begin
    ne_after = ne_w;
    if (is_add && !full_w[add_lvl]) begin
      ne_after[add_lvl] = 1'b1;
    end
    if (!is_add && any_ne && last_w[top_lvl]) begin
      ne_after[top_lvl] = 1'b0;
    end
  end

  always_comb begin
    cmd_info.all_empty = ~|ne_after;
    cmd_info.level     = '0;
    if (is_add) begin
      cmd_addr = {add_lvl, tail_r[add_lvl]};
      if (full_w[add_lvl]) begin
        cmd_info.kind   = mlpf_pkg::CMD_NONE;
        cmd_info.status = mlpf_pkg::ST_FULL;
      end else begin
        cmd_info.kind   = mlpf_pkg::CMD_WRITE;
        cmd_info.status = mlpf_pkg::ST_OK;
      end
    end else begin
      cmd_addr = {top_lvl, head_r[top_lvl]};
      if (any_ne) begin
        cmd_info.kind   = mlpf_pkg::CMD_READ;
        cmd_info.status = mlpf_pkg::ST_OK;
        cmd_info.level  = mlpf_pkg::LEVEL_PORT_W'(top_lvl);
      end else begin
        cmd_info.kind   = mlpf_pkg::CMD_NONE;
        cmd_info.status = mlpf_pkg::ST_EMPTY;
      end
    end
  end

  assign cmd_job = JOB_BITS'(job_in);

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (add_ok && add_lvl == LVL_W'(i)) begin
        tail_nxt[i] = next_slot(tail_r[i]);
        cnt_nxt[i]  = cnt_r[i] + 1'b1;
      end
      if (rem_ok && top_lvl == LVL_W'(i)) begin
        head_nxt[i] = next_slot(head_r[i]);
        cnt_nxt[i]  = cnt_r[i] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  generate
    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_chk
      a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_r[g] <= CNT_W'(LEVEL_DEPTH))
        else $error("level count beyond depth");
    end
  endgenerate

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ((ne_w == '0) == $past(cmd_info.all_empty)))
    else $error("all_empty disagrees with level counts");

endmodule

>>> rtl/mlpf_back.sv
// ----------------------------------------------------------------------------
// mlpf_back
// Executes store commands against the job RAM and forms result items.
// ----------------------------------------------------------------------------
module mlpf_back #(
  parameter int NUM_LEVELS  = mlpf_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpf_pkg::LEVEL_DEPTH_DEF,
  parameter int JOB_BITS    = mlpf_pkg::JOB_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cq_empty,
  input  mlpf_pkg::cmd_info_t                    cq_info,
  input  logic [$clog2(NUM_LEVELS)+$clog2(LEVEL_DEPTH)-1:0] cq_addr,
  input  logic [JOB_BITS-1:0]                    cq_job,
  output logic                                   cq_pop,
  input  logic [$clog2(mlpf_pkg::OQ_DEPTH+1)-1:0] oq_count,
  output logic                                   oq_push,
  output mlpf_pkg::result_t                      oq_data
);

  localparam int PTR_W    = $clog2(LEVEL_DEPTH);
  localparam int RAM_DEPTH = NUM_LEVELS * (2 ** PTR_W);

  logic                 issue;
  logic                 s2_valid_r, s2_valid_nxt;
  mlpf_pkg::cmd_info_t  s2_info_r;
  logic                 ram_we, ram_re;
  logic [JOB_BITS-1:0]  ram_rdata;

  // keep one result slot per command in flight
  assign issue = !cq_empty &&
                 ((int'(oq_count) + int'(s2_valid_r)) < mlpf_pkg::OQ_DEPTH);

  assign cq_pop       = issue;
  assign ram_we       = issue && (cq_info.kind == mlpf_pkg::CMD_WRITE);
  assign ram_re       = issue && (cq_info.kind == mlpf_pkg::CMD_READ);
  assign s2_valid_nxt = issue;

  mlpf_ram #(
    .WIDTH (JOB_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cq_addr),
    .wdata (cq_job),
    .re    (ram_re),
    .raddr (cq_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      if (issue) begin
        s2_info_r <= cq_info;
      end
    end
  end

  assign oq_push         = s2_valid_r;
  assign oq_data.job     = (s2_info_r.kind == mlpf_pkg::CMD_READ) ?
                           mlpf_pkg::JOB_PORT_W'(ram_rdata) : '0;
  assign oq_data.level   = s2_info_r.level;
  assign oq_data.status  = s2_info_r.status;
  assign oq_data.all_empty = s2_info_r.all_empty;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (int'(oq_count) < mlpf_pkg::OQ_DEPTH))
    else $error("result transfer into full queue");

  a_fail_no_access: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_info_r.status != mlpf_pkg::ST_OK)
      |-> (s2_info_r.kind == mlpf_pkg::CMD_NONE && $past(!ram_we && !ram_re)))
    else $error("failed item touched the job store");

endmodule

>>> rtl/multi_level_priority_fifo.sv
// ----------------------------------------------------------------------------
// multi_level_priority_fifo
// Job queue with per-level fifos; remove takes the oldest job of the highest
// non-empty level.
//
//   channel | ports                                            | direction
//   input   | in_push, in_full, in_op, in_job_in, in_prio_level | in
//   result  | out_pop, out_empty, out_job_out, out_level_out,   | out
//           | out_status, out_all_empty                         |
//
// One item accepted per cycle while in_full is low, one result per item; a
// result passes the command queue, the RAM read, then the result queue write.
// Throughput is set by the single job RAM port pair: one access per cycle
// while the result queue has room. Synchronous reset clears all level counts
// at once; no clearing pass. in_full rises when the command queue fills,
// which happens only when out_pop lags so far that the result queue fills.
// ----------------------------------------------------------------------------
module multi_level_priority_fifo #(
  parameter int NUM_LEVELS  = mlpf_pkg::NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlpf_pkg::LEVEL_DEPTH_DEF,
  parameter int JOB_BITS    = mlpf_pkg::JOB_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_op,
  input  logic [mlpf_pkg::JOB_PORT_W-1:0]   in_job_in,
  input  logic [mlpf_pkg::LEVEL_PORT_W-1:0] in_prio_level,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [mlpf_pkg::JOB_PORT_W-1:0]   out_job_out,
  output logic [mlpf_pkg::LEVEL_PORT_W-1:0] out_level_out,
  output logic [1:0]                        out_status,
  output logic                              out_all_empty
);

  localparam int ADDR_W = $clog2(NUM_LEVELS) + $clog2(LEVEL_DEPTH);
  localparam int INFO_W = $bits(mlpf_pkg::cmd_info_t);
  localparam int CMD_W  = INFO_W + ADDR_W + JOB_BITS;
  localparam int RES_W  = $bits(mlpf_pkg::result_t);
  localparam int OQ_CW  = $clog2(mlpf_pkg::OQ_DEPTH+1);

  logic                  acc;
  mlpf_pkg::cmd_info_t   fe_info, cq_info;
  logic [ADDR_W-1:0]     fe_addr, cq_addr;
  logic [JOB_BITS-1:0]   fe_job, cq_job;
  logic [CMD_W-1:0]      cq_rdata;
  logic                  cq_empty, cq_pop;
  logic [OQ_CW-1:0]      oq_count;
  logic                  oq_push;
  mlpf_pkg::result_t     oq_wdata, oq_rdata;
  logic [RES_W-1:0]      oq_rbits;

  assign acc = in_push & ~in_full;

  mlpf_front #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .JOB_BITS    (JOB_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .op         (in_op),
    .job_in     (in_job_in),
    .prio_level (in_prio_level),
    .cmd_info   (fe_info),
    .cmd_addr   (fe_addr),
    .cmd_job    (fe_job)
  );

  mlpf_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (mlpf_pkg::MID_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (acc),
    .wdata ({fe_info, fe_addr, fe_job}),
    .full  (in_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty),
    .count ()
  );

  assign cq_info = mlpf_pkg::cmd_info_t'(cq_rdata[CMD_W-1 -: INFO_W]);
  assign cq_addr = cq_rdata[JOB_BITS +: ADDR_W];
  assign cq_job  = cq_rdata[JOB_BITS-1:0];

  mlpf_back #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .JOB_BITS    (JOB_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_info  (cq_info),
    .cq_addr  (cq_addr),
    .cq_job   (cq_job),
    .cq_pop   (cq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  mlpf_fifo #(
    .WIDTH (RES_W),
    .DEPTH (mlpf_pkg::OQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (),
    .pop   (out_pop),
    .rdata (oq_rbits),
    .empty (out_empty),
    .count (oq_count)
  );

  assign oq_rdata      = mlpf_pkg::result_t'(oq_rbits);
  assign out_job_out   = oq_rdata.job;
  assign out_level_out = oq_rdata.level;
  assign out_status    = oq_rdata.status;
  assign out_all_empty = oq_rdata.all_empty;

endmodule

>>> tb/sv/tb_multi_level_priority_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_level_priority_fifo
// Self-checking testbench for the ten-level priority job queue. A short
// directed sequence covers the empty queue, the job and level extremes,
// out-of-range level saturation and the full-level drop. Random add/remove
// phases follow: they fill single levels to overflow and drain the queue
// again. A ring buffer per level predicts every result, and each popped
// result is compared field by field in order. The sender idles in bursts
// and the receiver stalls on its own pattern, so the block's full flag
// gets exercised.
// ----------------------------------------------------------------------------
module tb_multi_level_priority_fifo;

  localparam int NUM_LEVELS   = mlpf_pkg::NUM_LEVELS_DEF;
  localparam int LEVEL_DEPTH  = mlpf_pkg::LEVEL_DEPTH_DEF;
  localparam int JOB_W        = mlpf_pkg::JOB_PORT_W;
  localparam int LVL_W        = mlpf_pkg::LEVEL_PORT_W;
  localparam int RANDOM_ITEMS = 375;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic              in_op = mlpf_pkg::OP_ADD;
  logic [JOB_W-1:0]  in_job_in = '0;
  logic [LVL_W-1:0]  in_prio_level = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [JOB_W-1:0]  out_job_out;
  logic [LVL_W-1:0]  out_level_out;
  logic [1:0]        out_status;
  logic              out_all_empty;

  logic [JOB_W-1:0]    job_ring [NUM_LEVELS][LEVEL_DEPTH];
  int                  ring_head [NUM_LEVELS];
  int                  ring_count [NUM_LEVELS];
  mlpf_pkg::result_t   pending_results [$];
  int                  mismatch_count = 0;
  int                  pop_mode = 0;
  int                  pop_left = 0;

  multi_level_priority_fifo u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_op         (in_op),
    .in_job_in     (in_job_in),
    .in_prio_level (in_prio_level),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_job_out   (out_job_out),
    .out_level_out (out_level_out),
    .out_status    (out_status),
    .out_all_empty (out_all_empty)
  );

  always #5 clk = ~clk;

  function automatic mlpf_pkg::result_t apply_job_op(input mlpf_pkg::op_t op,
                                                     input logic [JOB_W-1:0] job,
                                                     input logic [LVL_W-1:0] prio);
    mlpf_pkg::result_t res;
    int                lvl;
    res = '0;
    res.status = mlpf_pkg::ST_OK;
    if (op == mlpf_pkg::OP_ADD) begin
      lvl = (prio >= NUM_LEVELS) ? NUM_LEVELS - 1 : int'(prio);
      if (ring_count[lvl] >= LEVEL_DEPTH) begin
        res.status = mlpf_pkg::ST_FULL;
      end else begin
        job_ring[lvl][(ring_head[lvl] + ring_count[lvl]) % LEVEL_DEPTH] = job;
        ring_count[lvl]++;
      end
    end else begin
      lvl = NUM_LEVELS - 1;
      while (lvl >= 0 && ring_count[lvl] == 0) lvl--;
      if (lvl < 0) begin
        res.status = mlpf_pkg::ST_EMPTY;
      end else begin
        res.job = job_ring[lvl][ring_head[lvl]];
        res.level = LVL_W'(lvl);
        ring_head[lvl] = (ring_head[lvl] + 1) % LEVEL_DEPTH;
        ring_count[lvl]--;
      end
    end
    res.all_empty = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ring_count[i] != 0) res.all_empty = 1'b0;
    end
    return res;
  endfunction

  // results are checked before the same edge's input transfer is predicted
  always @(posedge clk) begin : scoreboard
    mlpf_pkg::result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected result job=%h lvl=%0d st=%0d ae=%0b",
                   $time, out_job_out, out_level_out, out_status, out_all_empty);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_job_out !== want.job || out_level_out !== want.level ||
            out_status !== want.status || out_all_empty !== want.all_empty) begin
          if (mismatch_count < 10)
            $display("%0t: exp job=%h lvl=%0d st=%0d ae=%0b got job=%h lvl=%0d st=%0d ae=%0b",
                     $time, want.job, want.level, want.status, want.all_empty,
                     out_job_out, out_level_out, out_status, out_all_empty);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_push && !in_full)
      pending_results.push_back(apply_job_op(mlpf_pkg::op_t'(in_op), in_job_in,
                                             in_prio_level));
  end

  // receiver stall pattern: free run, coin flip, sparse pops, hard stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_left = 0;
    end else begin
      if (pop_left == 0) begin
        pop_mode = $urandom_range(3, 0);
        pop_left = (pop_mode == 3) ? $urandom_range(30, 5) : $urandom_range(80, 20);
      end
      pop_left--;
      case (pop_mode)
        0:       out_pop <= 1'b1;
        1:       out_pop <= ($urandom_range(1, 0) == 1);
        2:       out_pop <= ($urandom_range(5, 0) == 0);
        default: out_pop <= 1'b0;
      endcase
    end
  end

  task automatic send_item(input mlpf_pkg::op_t op, input logic [JOB_W-1:0] job,
                           input logic [LVL_W-1:0] prio);
    in_op <= op;
    in_job_in <= job;
    in_prio_level <= prio;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic test_remove_when_empty();
    send_item(mlpf_pkg::OP_REMOVE, 16'h1234, 4'd5);
  endtask

  task automatic test_level_extremes();
    send_item(mlpf_pkg::OP_ADD, 16'h0000, 4'd0);
    send_item(mlpf_pkg::OP_ADD, 16'hFFFF, 4'd15);
    send_item(mlpf_pkg::OP_ADD, 16'hA5A5, 4'd9);
    send_item(mlpf_pkg::OP_REMOVE, 16'hFFFF, 4'd15);
    send_item(mlpf_pkg::OP_REMOVE, 16'h0000, 4'd0);
    send_item(mlpf_pkg::OP_REMOVE, 16'h5A5A, 4'd10);
    send_item(mlpf_pkg::OP_REMOVE, 16'h0000, 4'd0);
  endtask

  task automatic test_full_level();
    for (int i = 0; i < LEVEL_DEPTH; i++)
      send_item(mlpf_pkg::OP_ADD, JOB_W'(16'h3000 + i), 4'd3);
    send_item(mlpf_pkg::OP_ADD, 16'hBEEF, 4'd3);
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase_len;
    int add_pct;
    int lvl_lo;
    int lvl_hi;
    int burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 20);
      case ($urandom_range(3, 0))
        0:       add_pct = 90;
        1:       add_pct = 65;
        2:       add_pct = 50;
        default: add_pct = 25;
      endcase
      if ($urandom_range(1, 0) == 1) begin
        lvl_lo = $urandom_range(15, 0);
        lvl_hi = lvl_lo;
      end else begin
        lvl_lo = 0;
        lvl_hi = 15;
      end
      while (phase_len > 0 && sent < RANDOM_ITEMS) begin
        burst = $urandom_range(16, 1);
        while (burst > 0 && phase_len > 0 && sent < RANDOM_ITEMS) begin
          send_item(($urandom_range(99, 0) < add_pct) ? mlpf_pkg::OP_ADD
                                                      : mlpf_pkg::OP_REMOVE,
                    JOB_W'($urandom()), LVL_W'($urandom_range(lvl_hi, lvl_lo)));
          burst--;
          phase_len--;
          sent++;
        end
        if ($urandom_range(3, 0) != 0) idle_gap($urandom_range(6, 1));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ring_head[i] = 0;
      ring_count[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_remove_when_empty();
    test_level_extremes();
    idle_gap(2);
    test_full_level();
    test_random_traffic();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
